// ----- sv/bdq_pkg.sv -----
// Shared types, constants and helper functions for the bounded deque block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // Storage geometry.
  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = ADDR_W + 1;

  // Fixed field widths of the request and result items.
  localparam int MODE_W = 3;
  localparam int POS_W  = 9;
  localparam int WORD_W = 32;
  localparam int ECNT_W = 9;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cnt_t CNT_FULL = CNT_W'(CAPACITY);

  // Mode codes carried in a request.
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

  // Decoded operation handed from the front end to the execution engine.
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_PUSH_BACK,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_READ,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [ECNT_W-1:0]        entry_count;
    logic                     is_full;
    logic                     op_error;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    data_t            value;
  } cmd_t;

  // Ring address of the entry that lies off places behind base.
  function automatic addr_t ring_add(input addr_t base, input cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Sign-extends a stored word to the result field width.
  function automatic logic signed [WORD_W-1:0] to_word(input data_t d);
    return WORD_W'(signed'(d));
  endfunction

endpackage

`default_nettype wire

// ----- sv/bdq_front.sv -----
// Front end of the bounded deque: takes requests, decodes the mode and holds
// them in a two-entry queue for the execution engine. Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_front import bdq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  input  wire logic     cmd_take,
  output cmd_t          cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       push_ok, take_ok;
  cmd_t       dec;

  // Decode the mode into an operation; unused codes become a bad operation.
  always_comb begin
    dec.position = in_item.position;
    dec.value    = DATA_WIDTH'(in_item.value);
    unique case (in_item.mode)
      MODE_INSERT:    dec.op = OP_INSERT;
      MODE_PUSH_BACK: dec.op = OP_PUSH_BACK;
      MODE_POP_BACK:  dec.op = OP_POP_BACK;
      MODE_POP_FRONT: dec.op = OP_POP_FRONT;
      MODE_READ:      dec.op = OP_READ;
      default:        dec.op = OP_BAD;
    endcase
  end

  // Queue handshake and pointer bookkeeping.
  assign in_full   = (q_cnt_r == 2'd2);
  assign cmd_valid = (q_cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign take_ok   = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push_ok ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take_ok ? !rd_ptr_r : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r + 2'(push_ok) - 2'(take_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // The queue slots hold payload only.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  // The queue never holds more than two requests.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'd2)
    else $error("request queue overflow");

  // The engine never takes a request from an empty queue.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("request taken from empty queue");

endmodule

`default_nettype wire

// ----- sv/bdq_back.sv -----
// Execution engine of the bounded deque: ring memory, count and front pointer,
// the sequencer that carries out each request, and the result register.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_back import bdq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cmd_valid,
  output logic       cmd_take,
  input  wire cmd_t  cmd,
  output logic       out_empty,
  input  wire logic  out_pop,
  output out_item_t  out_item
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SH_RD = 5'b00010,
    S_SH_WR = 5'b00100,
    S_INS   = 5'b01000,
    S_FETCH = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  cnt_t      count_r, count_nxt;
  addr_t     front_r, front_nxt;
  data_t     front_val_r, front_val_nxt;
  data_t     back_val_r, back_val_nxt;
  cnt_t      k_r, k_nxt;
  cmd_t      cur_r, cur_nxt;
  out_item_t out_r;
  logic      out_valid_r, out_valid_nxt;

  data_t     mem [CAPACITY];
  data_t     rd_data_r;
  logic      wr_en, rd_en;
  addr_t     wr_addr, rd_addr;
  data_t     wr_data;

  logic                     start, load, err;
  logic signed [WORD_W-1:0] rd_val;
  logic [CMP_W-1:0]         pos_c, cnt_c;
  cnt_t                     k_dec;
  out_item_t                res;

  assign start    = (state_r == S_IDLE) && cmd_valid && (!out_valid_r || out_pop);
  assign cmd_take = start;
  assign pos_c    = CMP_W'(cmd.position);
  assign cnt_c    = CMP_W'(count_r);
  assign k_dec    = k_r - CNT_W'(1);

  // Sequencer: legality check, memory accesses and shadow register updates.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    front_val_nxt = front_val_r;
    back_val_nxt  = back_val_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    load          = 1'b0;
    err           = 1'b0;
    rd_val        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cur_nxt = cmd;
          unique case (cmd.op)
            OP_INSERT, OP_PUSH_BACK: begin
              if (count_r == CNT_FULL || (cmd.op == OP_INSERT && pos_c > cnt_c)) begin
                err  = 1'b1;
                load = 1'b1;
              end else if (cmd.op == OP_PUSH_BACK || pos_c == cnt_c) begin
                // Append at the back in a single write.
                wr_en        = 1'b1;
                wr_addr      = ring_add(front_r, count_r);
                wr_data      = cmd.value;
                back_val_nxt = cmd.value;
                if (count_r == '0) begin
                  front_val_nxt = cmd.value;
                end
                count_nxt = count_r + CNT_W'(1);
                load      = 1'b1;
              end else begin
                // Move the tail up one place, starting at the back.
                k_nxt     = count_r;
                state_nxt = S_SH_RD;
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                err  = 1'b1;
                load = 1'b1;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (count_r == CNT_W'(1)) begin
                  load = 1'b1;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = ring_add(front_r, count_r - CNT_W'(2));
                  state_nxt = S_FETCH;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                err  = 1'b1;
                load = 1'b1;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                front_nxt = ring_add(front_r, CNT_W'(1));
                if (count_r == CNT_W'(1)) begin
                  load = 1'b1;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = ring_add(front_r, CNT_W'(1));
                  state_nxt = S_FETCH;
                end
              end
            end
            OP_READ: begin
              if (pos_c >= cnt_c) begin
                err  = 1'b1;
                load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ring_add(front_r, CNT_W'(cmd.position));
                state_nxt = S_FETCH;
              end
            end
            default: begin
              err  = 1'b1;
              load = 1'b1;
            end
          endcase
        end
      end
      S_SH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = ring_add(front_r, k_dec);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = ring_add(front_r, k_r);
        wr_data = rd_data_r;
        k_nxt   = k_dec;
        if (CMP_W'(k_dec) == CMP_W'(cur_r.position)) begin
          state_nxt = S_INS;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_INS: begin
        wr_en     = 1'b1;
        wr_addr   = ring_add(front_r, CNT_W'(cur_r.position));
        wr_data   = cur_r.value;
        count_nxt = count_r + CNT_W'(1);
        if (cur_r.position == '0) begin
          front_val_nxt = cur_r.value;
        end
        load      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FETCH: begin
        unique case (cur_r.op)
          OP_POP_BACK:  back_val_nxt  = rd_data_r;
          OP_POP_FRONT: front_val_nxt = rd_data_r;
          default:      rd_val        = to_word(rd_data_r);
        endcase
        load      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result built from the state after the operation.
  always_comb begin
    res.read_value  = rd_val;
    res.front_value = (count_nxt == '0) ? '0 : to_word(front_val_nxt);
    res.back_value  = (count_nxt == '0) ? '0 : to_word(back_val_nxt);
    res.entry_count = ECNT_W'(count_nxt);
    res.is_full     = (count_nxt == CNT_FULL);
    res.op_error    = err;
  end

  // The result register frees on a pop and fills on a load.
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      front_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    front_val_r <= front_val_nxt;
    back_val_r  <= back_val_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    if (load) begin
      out_r <= res;
    end
  end

  // Ring memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above capacity");

  // A result is only loaded into a free or draining result register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_pop))
    else $error("result overwritten before it was taken");

  // Shifting stops before it passes the insert position.
  a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SH_RD |-> CMP_W'(k_r) > CMP_W'(cur_r.position))
    else $error("shift went below insert position");

  // An empty buffer reports zero front and back values.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.entry_count == '0) |->
      (out_r.front_value == '0 && out_r.back_value == '0))
    else $error("nonzero front or back on empty buffer");

endmodule

`default_nettype wire

// ----- sv/bounded_deque_with_positional_insert_core.sv -----
// Top level of the bounded deque with positional insert.
// Depends on bdq_pkg, bdq_front and bdq_back.
`timescale 1ns / 1ps
`default_nettype none

// A ring buffer of 256 words with a queue-style interface on both sides. Each
// request inserts at a position, appends, pops the back or front, or reads a
// position, and yields one result with the word read, the front and back
// words, the count and full and error flags. Requests enter a two-entry queue
// and are executed one at a time by an engine built around a single memory
// with one write port and one registered read port. An error, an append or a
// pop that empties the buffer completes from idle; a legal pop or read waits
// for the registered read in a fetch state. An insert at position p moves
// each entry from p on up one place, one read and one write per entry, then
// writes the new word. A request is registered in the input queue before the
// engine takes it; the result register is refilled in the cycle it is popped.
// Entries are not cleared at reset; the buffer starts empty.
module bounded_deque_with_positional_insert_core import bdq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_item_t  in_item,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_item_t      out_item
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // Request decode and queue.
  bdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // Execution engine and result register.
  bdq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the bounded deque with positional insert.
// Depends on bdq_pkg and bounded_deque_with_positional_insert_core.
`timescale 1ns / 1ps

module testbench;
  import bdq_pkg::*;

  // Mode codes that the block treats as illegal.
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  // Watchdog limit, result hold-off, drain wait and request counts.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 440;
  localparam int CALM_ITEMS   = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  // Shadow copy of the buffer used to predict each result.
  logic [DATA_WIDTH-1:0] dq_mem [CAPACITY];
  int dq_count = 0;
  int dq_head = 0;

  out_item_t expected_q [$];
  int mismatch_count = 0;
  bit idle_on = 1'b1;
  bit filling = 1'b1;
  int hold_req = 0;

  bounded_deque_with_positional_insert_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ring slot of the entry that lies off places behind the front.
  function automatic int slot(input int off);
    return (dq_head + off) % CAPACITY;
  endfunction

  // Applies one request to the shadow buffer and returns the result it yields.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t res;
    int pos;
    bit err;
    logic [WORD_W-1:0] rd;
    pos = req.position;
    err = 1'b0;
    rd = '0;
    case (req.mode)
      MODE_INSERT: begin
        if (dq_count >= CAPACITY || pos > dq_count) begin
          err = 1'b1;
        end else begin
          for (int k = dq_count; k > pos; k--) begin
            dq_mem[slot(k)] = dq_mem[slot(k - 1)];
          end
          dq_mem[slot(pos)] = req.value[DATA_WIDTH-1:0];
          dq_count++;
        end
      end
      MODE_PUSH_BACK: begin
        if (dq_count >= CAPACITY) begin
          err = 1'b1;
        end else begin
          dq_mem[slot(dq_count)] = req.value[DATA_WIDTH-1:0];
          dq_count++;
        end
      end
      MODE_POP_BACK: begin
        if (dq_count == 0) begin
          err = 1'b1;
        end else begin
          dq_count--;
        end
      end
      MODE_POP_FRONT: begin
        if (dq_count == 0) begin
          err = 1'b1;
        end else begin
          dq_head = slot(1);
          dq_count--;
        end
      end
      MODE_READ: begin
        if (pos >= dq_count) begin
          err = 1'b1;
        end else begin
          rd = WORD_W'(signed'(dq_mem[slot(pos)]));
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
    res.read_value = rd;
    if (dq_count == 0) begin
      res.front_value = '0;
      res.back_value = '0;
    end else begin
      res.front_value = WORD_W'(signed'(dq_mem[slot(0)]));
      res.back_value = WORD_W'(signed'(dq_mem[slot(dq_count - 1)]));
    end
    res.entry_count = ECNT_W'(dq_count);
    res.is_full = (dq_count == CAPACITY);
    res.op_error = err;
    return res;
  endfunction

  function automatic in_item_t make_request(input logic [MODE_W-1:0] mode, input int pos,
                                            input logic [WORD_W-1:0] value);
    in_item_t req;
    req.mode = mode;
    req.position = POS_W'(pos);
    req.value = value;
    return req;
  endfunction

  // Data word with a bias toward the signed extremes, zero and minus one.
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal requests; the mix swings between filling and draining so that
  // the count travels between empty and full.
  function automatic in_item_t random_request();
    int r;
    int pos;
    int reach;
    if (filling && dq_count == CAPACITY) filling = 1'b0;
    else if (!filling && dq_count == 0) filling = 1'b1;
    else if ($urandom_range(0, 199) == 0) filling = !filling;
    r = $urandom_range(0, 99);
    // Most inserts land near the back to keep the shift cost low.
    reach = (dq_count < 8) ? dq_count : 8;
    if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, dq_count);
    else pos = dq_count - int'($urandom_range(0, reach));
    if (r >= 93) begin
      return make_request(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 511),
                          random_word());
    end
    if (filling) begin
      if (r < 25) return make_request(MODE_INSERT, pos, random_word());
      if (r < 60) return make_request(MODE_PUSH_BACK, 0, random_word());
      if (r < 67) return make_request(MODE_POP_BACK, 0, random_word());
      if (r < 74) return make_request(MODE_POP_FRONT, 0, random_word());
    end else begin
      if (r < 8) return make_request(MODE_INSERT, pos, random_word());
      if (r < 18) return make_request(MODE_PUSH_BACK, 0, random_word());
      if (r < 45) return make_request(MODE_POP_BACK, 0, random_word());
      if (r < 72) return make_request(MODE_POP_FRONT, 0, random_word());
    end
    pos = (dq_count > 0) ? $urandom_range(0, dq_count - 1) : 0;
    return make_request(MODE_READ, pos, random_word());
  endfunction

  // Offers one request, optionally after a gap, and waits until it is taken.
  task automatic send_request(input in_item_t req);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
    expected_q.push_back(apply_request(req));
    @(negedge clk);
  endtask

  // Result side: random pop gaps, plus a long hold-off when one is requested.
  always @(negedge clk) begin : result_receiver
    int hold_left;
    int pop_gap;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      out_pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      pop_gap = $urandom_range(1, 13) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Each popped result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin : result_checker
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $error("result popped with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        compare_field("read_value", want.read_value, out_item.read_value);
        compare_field("front_value", want.front_value, out_item.front_value);
        compare_field("back_value", want.back_value, out_item.back_value);
        compare_field("entry_count", want.entry_count, out_item.entry_count);
        compare_field("is_full", want.is_full, out_item.is_full);
        compare_field("op_error", want.op_error, out_item.op_error);
      end
    end
  end

  // Ends the run when neither side has moved a request for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Removals, reads and inserts on an empty buffer, and the unused mode codes.
  task automatic test_empty_errors();
    send_request(make_request(MODE_POP_BACK, 0, 32'h0));
    send_request(make_request(MODE_POP_FRONT, 0, 32'h0));
    send_request(make_request(MODE_READ, 0, 32'h0));
    send_request(make_request(MODE_INSERT, 1, 32'h1234_5678));
    send_request(make_request(MODE_RSVD5, 0, 32'hffff_ffff));
    send_request(make_request(MODE_RSVD6, 511, 32'h8000_0000));
    send_request(make_request(MODE_RSVD7, 256, 32'h7fff_ffff));
  endtask

  // Every operation on a small buffer, with positions at and past the count.
  task automatic test_basic_ops();
    send_request(make_request(MODE_INSERT, 0, 32'h7fff_ffff));
    send_request(make_request(MODE_PUSH_BACK, 0, 32'h8000_0000));
    send_request(make_request(MODE_INSERT, 1, 32'hffff_ffff));
    send_request(make_request(MODE_INSERT, 3, 32'h0000_0000));
    send_request(make_request(MODE_INSERT, 5, 32'h5a5a_a5a5));
    send_request(make_request(MODE_INSERT, 0, 32'ha5a5_5a5a));
    send_request(make_request(MODE_READ, 0, 32'h0));
    send_request(make_request(MODE_READ, 4, 32'h0));
    send_request(make_request(MODE_READ, 5, 32'h0));
    send_request(make_request(MODE_READ, 511, 32'h0));
    send_request(make_request(MODE_POP_FRONT, 0, 32'h0));
    send_request(make_request(MODE_POP_BACK, 0, 32'h0));
    send_request(make_request(MODE_PUSH_BACK, 0, 32'h0000_0001));
  endtask

  // Fills to capacity, checks the full-buffer errors, wraps the ring, drains.
  task automatic test_fill_and_drain();
    while (dq_count < CAPACITY) begin
      send_request(make_request(MODE_PUSH_BACK, 0, random_word()));
    end
    send_request(make_request(MODE_PUSH_BACK, 0, 32'h1111_1111));
    send_request(make_request(MODE_INSERT, 0, 32'h2222_2222));
    send_request(make_request(MODE_INSERT, CAPACITY, 32'h3333_3333));
    send_request(make_request(MODE_READ, CAPACITY - 1, 32'h0));
    send_request(make_request(MODE_READ, CAPACITY, 32'h0));
    send_request(make_request(MODE_POP_FRONT, 0, 32'h0));
    // Longest shift: insert at the front of a buffer one short of full.
    send_request(make_request(MODE_INSERT, 0, 32'h8000_0000));
    repeat (100) send_request(make_request(MODE_POP_FRONT, 0, 32'h0));
    repeat (90) send_request(make_request(MODE_PUSH_BACK, 0, random_word()));
    send_request(make_request(MODE_INSERT, dq_count / 2, 32'h7fff_ffff));
    send_request(make_request(MODE_READ, dq_count / 2, 32'h0));
    while (dq_count > 0) begin
      if ($urandom_range(0, 1) == 0) send_request(make_request(MODE_POP_BACK, 0, 32'h0));
      else send_request(make_request(MODE_POP_FRONT, 0, 32'h0));
    end
  endtask

  // The result side holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    repeat (40) send_request(random_request());
  endtask

  task automatic test_random(input int count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_errors();
    test_basic_ops();
    test_fill_and_drain();
    test_backpressure();
    test_random(RANDOM_ITEMS);
    // Final stretch runs both sides at full rate.
    idle_on = 1'b0;
    test_random(CALM_ITEMS);
    in_push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
